@@ src/qd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qd_pkg: shared types and codes of the quiescence detector
// Beat layouts of both channels, item kinds and result status codes.
// ----------------------------------------------------------------------------
package qd_pkg;

  localparam logic [1:0] KIND_ENTER  = 2'd0;
  localparam logic [1:0] KIND_EXIT   = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_DONE = 2'd1;
  localparam logic [1:0] ST_LATE     = 2'd2;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  core;
    logic [63:0] stamp;
    logic [63:0] now;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] quiescence;
  } result_t;

  // One memory row: entry time, exit time and a third word
  // (known quiescence for published rows, refresh time for cached rows).
  typedef struct packed {
    logic [63:0] t_in;
    logic [63:0] t_out;
    logic [63:0] aux;
  } row_t;

endpackage

`default_nettype wire

@@ src/qd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qd_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qd_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/quiescence_detector_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quiescence_detector_top: wait-free grace-period detector
// Tracks per-core section enter/exit times and answers quiescence queries.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Every beat gives exactly
// one result beat, shown for a single cycle with result_valid_o high; the
// receiver cannot hold it off, so it must sample it in that cycle. After reset
// the block sweeps both state memories, one row a cycle, over all CORES*CORES
// rows of the cached-copy memory, and holds busy high meanwhile. An enter or
// exit beat reads, then writes back, the published row; an ignored beat (unused kind
// or core number at or above CORES) answers with no memory access. A query
// reads the asker's row and answers at once if late; else it visits the other
// cores in turn, with a recheck for each cached copy that must be refreshed,
// and ends with a write-back. The walk visits the cached-copy memory one entry
// at a time through its single read port.
// ----------------------------------------------------------------------------
module quiescence_detector_top
  import qd_pkg::*;
#(
  parameter int CORES = 8
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire item_t   item_i,
  output logic         result_valid_o,
  output result_t      result_o
);

  localparam int CW = $clog2(CORES);
  localparam int KW = $clog2(CORES * CORES);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EVENT = 7'b0000100,
    S_OWN   = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_RECHK = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [KW-1:0]   clr_q, clr_d;
  item_t           item_q, item_d;
  logic [CW-1:0]   own_q, own_d;
  logic [KW-1:0]   base_q, base_d;
  logic [CW-1:0]   r_q, r_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [KW-1:0]   caddr_q, caddr_d;
  logic [63:0]     kq_q, kq_d;
  logic [63:0]     qsc_q, qsc_d;
  logic [63:0]     minq_q, minq_d;
  logic [63:0]     own_in_q, own_in_d;
  logic [63:0]     own_out_q, own_out_d;
  logic            inside_q, inside_d;
  logic            broke_q, broke_d;
  row_t            copy_q, copy_d;
  logic            res_valid_q, res_valid_d;
  result_t         res_q, res_d;

  // memory ports
  logic            pub_we, pub_re, cache_we, cache_re;
  logic [CW-1:0]   pub_waddr, pub_raddr;
  logic [KW-1:0]   cache_waddr, cache_raddr;
  row_t            pub_wdata, cache_wdata, pub_rdata, cache_rdata;

  qd_ram #(.WIDTH($bits(row_t)), .DEPTH(CORES)) u_pub (
    .clk_i   (clk_i),
    .we_i    (pub_we),
    .waddr_i (pub_waddr),
    .wdata_i (pub_wdata),
    .re_i    (pub_re),
    .raddr_i (pub_raddr),
    .rdata_o (pub_rdata)
  );

  qd_ram #(.WIDTH($bits(row_t)), .DEPTH(CORES * CORES)) u_cache (
    .clk_i   (clk_i),
    .we_i    (cache_we),
    .waddr_i (cache_waddr),
    .wdata_i (cache_wdata),
    .re_i    (cache_re),
    .raddr_i (cache_raddr),
    .rdata_o (cache_rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Per-step checks on the copy under test (memory data or the refreshed copy)
  row_t        chk;
  logic        chk_done;
  logic [63:0] chk_val;
  logic        early_stop;
  logic [CW-1:0] r_next;
  logic        last_step;
  logic [63:0] fin_min;

  always_comb begin
    chk        = state_q[5] ? copy_q : cache_rdata;
    chk_done   = (item_q.stamp < chk.t_in) ||
                 ((item_q.stamp < chk.aux) && (chk.t_in < chk.t_out));
    chk_val    = (chk.t_in < chk.t_out) ? chk.aux : chk.t_in;
    early_stop = item_q.stamp < kq_q;
    r_next     = (r_q == CW'(CORES - 1)) ? '0 : r_q + 1'b1;
    last_step  = (cnt_q == CW'(1));
    fin_min    = (inside_q && (minq_q > own_in_q)) ? own_in_q : minq_q;
  end

  logic          acc;
  logic          core_ok;
  logic [CW-1:0] c_in;
  logic [CW-1:0] r_first;

  always_comb begin
    acc      = start && !busy;
    core_ok  = 32'(item_i.core) < CORES;
    c_in     = CW'(item_i.core);
    r_first  = (c_in == CW'(CORES - 1)) ? '0 : c_in + 1'b1;

    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    own_d       = own_q;
    base_d      = base_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    caddr_d     = caddr_q;
    kq_d        = kq_q;
    qsc_d       = qsc_q;
    minq_d      = minq_q;
    own_in_d    = own_in_q;
    own_out_d   = own_out_q;
    inside_d    = inside_q;
    broke_d     = broke_q;
    copy_d      = copy_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    pub_we      = 1'b0;
    pub_waddr   = own_q;
    pub_wdata   = '{t_in: own_in_q, t_out: own_out_q, aux: kq_q};
    pub_re      = 1'b0;
    pub_raddr   = c_in;
    cache_we    = 1'b0;
    cache_waddr = caddr_q;
    cache_wdata = '{t_in: pub_rdata.t_in, t_out: pub_rdata.t_out, aux: item_q.now};
    cache_re    = 1'b0;
    cache_raddr = caddr_q;

    case (state_q)
      S_CLEAR: begin
        // sweep both memories to their reset rows
        cache_we    = 1'b1;
        cache_waddr = clr_q;
        cache_wdata = '{t_in: 64'd0, t_out: 64'd1, aux: 64'd0};
        pub_we      = clr_q < KW'(CORES);
        pub_waddr   = CW'(clr_q);
        pub_wdata   = '{t_in: 64'd0, t_out: 64'd1, aux: 64'd0};
        clr_d       = clr_q + 1'b1;
        if (clr_q == KW'(CORES * CORES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          item_d = item_i;
          own_d  = c_in;
          if (core_ok && (item_i.kind == KIND_QUERY)) begin
            pub_re  = 1'b1;
            base_d  = KW'(KW'(c_in) * KW'(CORES));
            r_d     = r_first;
            state_d = S_OWN;
          end else if (core_ok && ((item_i.kind == KIND_ENTER) ||
                                   (item_i.kind == KIND_EXIT))) begin
            pub_re  = 1'b1;
            state_d = S_EVENT;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{status: ST_OK, quiescence: 64'd0};
          end
        end
      end
      S_EVENT: begin
        pub_we    = 1'b1;
        pub_wdata = pub_rdata;
        if (item_q.kind == KIND_ENTER) begin
          pub_wdata.t_in = item_q.stamp;
        end else begin
          pub_wdata.t_out = item_q.stamp;
        end
        res_valid_d = 1'b1;
        res_d       = '{status: ST_OK, quiescence: 64'd0};
        state_d     = S_IDLE;
      end
      S_OWN: begin
        own_in_d  = pub_rdata.t_in;
        own_out_d = pub_rdata.t_out;
        kq_d      = pub_rdata.aux;
        qsc_d     = pub_rdata.aux;
        inside_d  = !(pub_rdata.t_out > pub_rdata.t_in);
        if (!(pub_rdata.t_out > pub_rdata.t_in) && (item_q.stamp > pub_rdata.t_in)) begin
          res_valid_d = 1'b1;
          res_d       = '{status: ST_LATE, quiescence: pub_rdata.aux};
          state_d     = S_IDLE;
        end else begin
          minq_d      = ALL_ONES;
          broke_d     = 1'b0;
          cnt_d       = CW'(CORES - 1);
          pub_re      = 1'b1;
          pub_raddr   = r_q;
          cache_re    = 1'b1;
          cache_raddr = base_q + KW'(r_q);
          caddr_d     = base_q + KW'(r_q);
          state_d     = S_WALK;
        end
      end
      S_WALK, S_RECHK: begin
        if (early_stop) begin
          broke_d = 1'b1;
          state_d = S_FIN;
        end else if (chk_done) begin
          if (minq_q > chk_val) begin
            minq_d = chk_val;
          end
          if (last_step) begin
            state_d = S_FIN;
          end else begin
            // advance to the next core
            r_d         = r_next;
            cnt_d       = cnt_q - 1'b1;
            pub_re      = 1'b1;
            pub_raddr   = r_next;
            cache_re    = 1'b1;
            cache_raddr = base_q + KW'(r_next);
            caddr_d     = base_q + KW'(r_next);
            state_d     = S_WALK;
          end
        end else if (state_q == S_WALK) begin
          // refresh the copy once, then check again
          cache_we = 1'b1;
          copy_d   = '{t_in: pub_rdata.t_in, t_out: pub_rdata.t_out, aux: item_q.now};
          if (kq_q < pub_rdata.aux) begin
            kq_d = pub_rdata.aux;
          end
          state_d = S_RECHK;
        end else begin
          // still not done: keep any raise from refreshes, report failure
          pub_we      = 1'b1;
          res_valid_d = 1'b1;
          res_d       = '{status: ST_NOT_DONE, quiescence: qsc_q};
          state_d     = S_IDLE;
        end
      end
      S_FIN: begin
        pub_we = 1'b1;
        res_d  = '{status: ST_OK, quiescence: qsc_q};
        if (!broke_q && (kq_q < fin_min)) begin
          pub_wdata.aux = fin_min;
          res_d.quiescence = fin_min;
        end
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    own_q     <= own_d;
    base_q    <= base_d;
    r_q       <= r_d;
    cnt_q     <= cnt_d;
    caddr_q   <= caddr_d;
    kq_q      <= kq_d;
    qsc_q     <= qsc_d;
    minq_q    <= minq_d;
    own_in_q  <= own_in_d;
    own_out_q <= own_out_d;
    inside_q  <= inside_d;
    broke_q   <= broke_d;
    copy_q    <= copy_d;
    res_q     <= res_d;
  end

  // A query beat never answers in the next cycle: the asker's row is still being read.
  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.kind == KIND_QUERY) && (32'(item_i.core) < CORES))
      |=> !result_valid_o)
    else $error("query answered without reading its row");

  // Results leave only on the way back to idle.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  // A failed query follows a recheck of a refreshed copy.
  a_fail_after_recheck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status == ST_NOT_DONE)) |-> ($past(state_q) == S_RECHK))
    else $error("failure reported without a refresh");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the quiescence detector
// Drives enter, exit and query beats through the start/busy handshake,
// predicts every result with a behavioural model of the grace-period walk
// and compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import qd_pkg::*;

  localparam int NCORES   = 8;
  localparam int WD_LIMIT = 20000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  logic    result_valid_o;
  result_t result_o;

  quiescence_detector_top #(.CORES(NCORES)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: mirrors the block's published and cached tables.
  logic [63:0] pub_in [NCORES];
  logic [63:0] pub_out [NCORES];
  logic [63:0] known_q [NCORES];
  logic [63:0] cache_in [NCORES*NCORES];
  logic [63:0] cache_out [NCORES*NCORES];
  logic [63:0] cache_when [NCORES*NCORES];

  item_t   pending_beats[$];
  result_t expected_results[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      n_queries = 0;
  int      n_late = 0;
  int      n_not_done = 0;
  int      idle_pct = 0;
  bit      hold_send = 0;

  // Handshake state captured at the rising edge for the driver, and the monitor's watchdog count.
  logic busy_at_edge = 1'b1;
  int   quiet_cycles = 0;

  task automatic report(input string what);
    n_errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  task automatic clear_tables();
    for (int i = 0; i < NCORES; i++) begin
      pub_in[i] = '0;
      pub_out[i] = 64'd1;
      known_q[i] = '0;
    end
    for (int i = 0; i < NCORES*NCORES; i++) begin
      cache_in[i] = '0;
      cache_out[i] = 64'd1;
      cache_when[i] = '0;
    end
  endtask

  // Work out the result of one beat and advance the predicted tables.
  function automatic result_t predict_grace(input item_t it);
    result_t     res;
    int          c, r, k;
    logic [63:0] t, minq, ci, co, cu, v;
    bit          in_sect, broke, settled;
    res = '0;
    c = it.core;
    t = it.stamp;
    if (c >= NCORES || !(it.kind inside {KIND_ENTER, KIND_EXIT, KIND_QUERY}))
      return res;
    if (it.kind == KIND_ENTER) begin
      pub_in[c] = t;
      return res;
    end
    if (it.kind == KIND_EXIT) begin
      pub_out[c] = t;
      return res;
    end
    in_sect = !(pub_out[c] > pub_in[c]);
    res.quiescence = known_q[c];
    if (in_sect && t > pub_in[c]) begin
      res.status = ST_LATE;
      return res;
    end
    minq = ALL_ONES;
    broke = 0;
    for (int i = 1; i < NCORES && !broke; i++) begin
      r = (c + i) % NCORES;
      k = c * NCORES + r;
      settled = 0;
      for (int attempt = 0; attempt < 2 && !settled; attempt++) begin
        if (t < known_q[c]) begin
          broke = 1;
          settled = 1;
        end else begin
          ci = cache_in[k];
          co = cache_out[k];
          cu = cache_when[k];
          if (t < ci || (t < cu && ci < co)) begin
            v = (ci < co) ? cu : ci;
            if (minq > v) minq = v;
            settled = 1;
          end else if (attempt > 0) begin
            res.status = ST_NOT_DONE;
            return res;
          end else begin
            cache_in[k] = pub_in[r];
            cache_out[k] = pub_out[r];
            cache_when[k] = it.now;
            if (known_q[c] < known_q[r]) known_q[c] = known_q[r];
          end
        end
      end
    end
    if (!broke) begin
      if (in_sect && minq > pub_in[c]) minq = pub_in[c];
      if (known_q[c] < minq) begin
        known_q[c] = minq;
        res.quiescence = minq;
      end
    end
    return res;
  endfunction

  function automatic item_t make_beat(input logic [1:0] kind, input logic [2:0] core,
                                      input logic [63:0] stamp, input logic [63:0] now);
    item_t it;
    it.kind = kind;
    it.core = core;
    it.stamp = stamp;
    it.now = now;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Driver: present the head of the queue, pop it once it is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy_at_edge) begin
        void'(pending_beats.pop_front());
      end
      if (pending_beats.size() != 0 && !hold_send &&
          ($urandom_range(99) >= idle_pct || (start && busy_at_edge))) begin
        start <= 1'b1;
        item_i <= pending_beats[0];
      end else begin
        start <= 1'b0;
        item_i <= make_beat(2'($urandom()), 3'($urandom()), rand64(), rand64());
      end
    end
  end

  // Monitor: predict on acceptance, compare on every result beat.
  always @(posedge clk_i) begin
    bit      moved;
    result_t exp_r;
    moved = 1'b0;
    busy_at_edge <= busy;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.push_back(predict_grace(item_i));
        moved = 1'b1;
        if (item_i.kind == KIND_QUERY) n_queries++;
      end
      if (result_valid_o) begin
        moved = 1'b1;
        n_checked++;
        if (expected_results.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (result_o.status != exp_r.status)
            report($sformatf("status %0d, expected %0d", result_o.status, exp_r.status));
          if (result_o.quiescence != exp_r.quiescence)
            report($sformatf("quiescence %h, expected %h",
                             result_o.quiescence, exp_r.quiescence));
          if (exp_r.status == ST_LATE) n_late++;
          if (exp_r.status == ST_NOT_DONE) n_not_done++;
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles > WD_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", expected_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stamps are drawn near a moving clock so that comparisons go both ways.
  logic [63:0] clock_base = 64'd1000;

  function automatic logic [63:0] near_stamp();
    case ($urandom_range(9))
      0: return rand64();
      1: return 64'd0;
      2: return ALL_ONES - $urandom_range(3);
      default: return clock_base - 64'd40 + $urandom_range(60);
    endcase
  endfunction

  task automatic queue_random(input int count);
    logic [1:0] kind;
    logic [2:0] core;
    for (int n = 0; n < count; n++) begin
      clock_base += $urandom_range(8);
      core = 3'($urandom_range(7));
      // Mostly enter, exit and query beats, some noise kinds.
      case ($urandom_range(19))
        0:           kind = KIND_UNUSED;
        1,2,3,4,5:   kind = KIND_ENTER;
        6,7,8,9,10:  kind = KIND_EXIT;
        default:     kind = KIND_QUERY;
      endcase
      pending_beats.push_back(make_beat(kind, core, near_stamp(),
                                        ($urandom_range(15) == 0) ? rand64()
                                                                  : clock_base));
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || start) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2 * NCORES + 4) @(posedge clk_i);
  endtask

  initial begin
    clear_tables();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: every kind, ignored beats, field extremes, each query outcome.
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd0, 64'd0, 64'd5));
    pending_beats.push_back(make_beat(KIND_ENTER, 3'd1, 64'd100, 64'd0));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd1, 64'd200, 64'd200));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd0, 64'd150, 64'd300));
    pending_beats.push_back(make_beat(KIND_EXIT, 3'd1, 64'd120, ALL_ONES));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd0, 64'd150, 64'd400));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd2, 64'd10, 64'd500));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd2, 64'd5, 64'd600));
    pending_beats.push_back(make_beat(KIND_UNUSED, 3'd7, ALL_ONES, ALL_ONES));
    pending_beats.push_back(make_beat(KIND_ENTER, 3'd7, ALL_ONES, 64'd0));
    pending_beats.push_back(make_beat(KIND_EXIT, 3'd7, 64'd0, ALL_ONES));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd7, ALL_ONES, ALL_ONES));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd7, 64'd0, 64'd0));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd5, 64'h5555_5555_5555_5555,
                                      64'hAAAA_AAAA_AAAA_AAAA));
    pending_beats.push_back(make_beat(KIND_QUERY, 3'd6, 64'hAAAA_AAAA_AAAA_AAAA,
                                      64'h5555_5555_5555_5555));
    wait_drained();

    // Random phases, each with its own idling pattern on the sender side.
    idle_pct = 0;   queue_random(200); wait_drained();
    idle_pct = 79;  queue_random(150);
    // Pause the sender once until every prediction is met.
    while (pending_beats.size() > 70) @(posedge clk_i);
    hold_send = 1;
    while (start || expected_results.size() != 0) @(posedge clk_i);
    hold_send = 0;
    wait_drained();
    idle_pct = 28;  queue_random(200); wait_drained();
    idle_pct = 0;   queue_random(150); wait_drained();

    $display("covered %0d result beats, %0d queries (%0d late, %0d not quiescent)",
             n_checked, n_queries, n_late, n_not_done);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/qd_pkg.sv
src/qd_ram.sv
src/quiescence_detector_top.sv
bench/tb.sv
